// File: src/fys_pkg.sv
// shared types, codes and face helpers for the shuffle engine
package fys_pkg;

    // action codes of an input item
    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_STEP = 2'd1,
        ACT_READ = 2'd2
    } t_action;

    // status codes of a result item
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FINISHED = 2'd1,
        STAT_IGNORED  = 2'd2,
        STAT_RANGE    = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_DIV1,
        S_DIV2,
        S_RD_I,
        S_RD_J,
        S_SWAP,
        S_WR_J,
        S_RDOUT,
        S_DONE
    } t_state;

    // input item
    typedef struct packed {
        logic [1:0]  action;
        logic [30:0] random_word;
        logic [8:0]  read_index;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [9:0] entry_value;
        logic [4:0] face_d20;
        logic [6:0] face_d100;
        logic [1:0] status;
    } t_out_item;

    // shared divider geometry: radix-2 restoring, two quotient bits per cycle
    localparam int DIV_W     = 32;
    localparam int DIV_STEPS = 2;
    localparam int DIV_ITERS = DIV_W / DIV_STEPS;
    localparam int ITER_W    = $clog2(DIV_ITERS);

    // d20 face: v mod 20 by reciprocal multiply, zero shown as twenty
    function automatic logic [4:0] f_face_d20(input logic [9:0] v);
        logic [21:0] prod;
        logic [5:0]  q;
        logic [9:0]  m;
        prod = 22'(v) * 22'd3277;
        q    = prod[21:16];
        m    = v - 10'(10'(q) * 10'd20);
        if (m == 10'd0) begin
            m = 10'd20;
        end
        return 5'(m);
    endfunction

    // d100 face: v mod 100 by reciprocal multiply, zero shown as one hundred
    function automatic logic [6:0] f_face_d100(input logic [9:0] v);
        logic [20:0] prod;
        logic [3:0]  q;
        logic [9:0]  m;
        prod = 21'(v) * 21'd1311;
        q    = prod[20:17];
        m    = v - 10'(10'(q) * 10'd100);
        if (m == 10'd0) begin
            m = 10'd100;
        end
        return 7'(m);
    endfunction

endpackage

// File: src/fisher_yates_shuffle_engine_unit.sv
// Fisher-Yates shuffle engine: deck table, shared divider and sequencer
// One item at a time. An init item fills the first count entries, one per cycle. A swap
// step runs two 32-bit divisions on one shared restoring divider that retires two
// quotient bits a cycle, then reads, swaps and writes back two entries through the
// table's one read and one write port. An item's result is held in the hand-off state
// while the previous result still waits in the output register.
// The result goes to an output register, so the next item is taken while that result
// still waits. Reading an entry that no init has written returns an arbitrary value.
// The effective count is deck_count held to the range 1..DECK_DEPTH; the user must write
// deck_count only while the block is idle, which the block itself does not enforce.
module fisher_yates_shuffle_engine_unit
    import fys_pkg::*;
#(
    parameter int DECK_DEPTH = 512,
    parameter int RANDOM_MAX = 2147483647
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out,
    input  logic       i_cfg_wr_en,
    input  logic [9:0] i_cfg_wr_data
);

    localparam int          ADDR_W = $clog2(DECK_DEPTH);
    localparam logic [30:0] RM     = 31'(RANDOM_MAX);

    // control registers
    t_state            r_state,       n_state;
    logic [9:0]        r_deck_count;
    logic [9:0]        r_step_idx,    n_step_idx;
    logic              r_finished,    n_finished;
    logic              r_out_valid,   n_out_valid;

    // working registers
    logic [9:0]        r_ptr,         n_ptr;
    logic [9:0]        r_j,           n_j;
    logic [9:0]        r_ti,          n_ti;
    logic [30:0]       r_rsat,        n_rsat;
    logic [DIV_W-1:0]  r_dvd,         n_dvd;
    logic [DIV_W-1:0]  r_dvs,         n_dvs;
    logic [DIV_W-1:0]  r_prem,        n_prem;
    logic [DIV_W-1:0]  r_quo,         n_quo;
    logic [ITER_W-1:0] r_iter,        n_iter;
    t_out_item         r_res,         n_res;
    t_out_item         r_out,         n_out;

    // table port
    logic [9:0]        r_deck_table [DECK_DEPTH];
    logic [9:0]        r_rd_data;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [9:0]        w_wdata;
    logic [ADDR_W-1:0] w_raddr;

    // derived values
    logic [9:0]        w_cnt;
    logic [9:0]        w_rem;
    logic [DIV_W-1:0]  w_div_prem;
    logic [DIV_W-1:0]  w_div_quo;
    logic [DIV_W-1:0]  w_div_dvd;
    logic              w_accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_rem       = w_cnt - r_step_idx;

    // effective count held to 1..DECK_DEPTH
    always_comb begin
        if (r_deck_count == 10'd0) begin
            w_cnt = 10'd1;
        end else if (32'(r_deck_count) > 32'(DECK_DEPTH)) begin
            w_cnt = 10'(DECK_DEPTH);
        end else begin
            w_cnt = r_deck_count;
        end
    end

    // shared divider: two restoring steps per cycle
    always_comb begin
        logic [DIV_W-1:0] prem;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] dvd;
        prem = r_prem;
        quo  = r_quo;
        dvd  = r_dvd;
        for (int k = 0; k < DIV_STEPS; k++) begin
            prem = {prem[DIV_W-2:0], dvd[DIV_W-1]};
            dvd  = {dvd[DIV_W-2:0], 1'b0};
            if (prem >= r_dvs) begin
                prem = prem - r_dvs;
                quo  = {quo[DIV_W-2:0], 1'b1};
            end else begin
                quo  = {quo[DIV_W-2:0], 1'b0};
            end
        end
        w_div_prem = prem;
        w_div_quo  = quo;
        w_div_dvd  = dvd;
    end

    // sequencer next state and table controls
    always_comb begin
        n_state     = r_state;
        n_step_idx  = r_step_idx;
        n_finished  = r_finished;
        n_ptr       = r_ptr;
        n_j         = r_j;
        n_ti        = r_ti;
        n_rsat      = r_rsat;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_prem      = r_prem;
        n_quo       = r_quo;
        n_iter      = r_iter;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = ADDR_W'(r_ptr);
        w_wdata     = r_ptr + 10'd1;
        w_raddr     = ADDR_W'(i_in.read_index);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res = '0;
                    unique case (i_in.action)
                        ACT_INIT: begin
                            n_ptr      = '0;
                            n_step_idx = '0;
                            n_finished = (w_cnt == 10'd1);
                            n_state    = S_FILL;
                        end
                        ACT_STEP: begin
                            if (r_finished) begin
                                n_res.status = STAT_IGNORED;
                                n_state      = S_DONE;
                            end else if (11'(r_step_idx) + 11'd1 >= 11'(w_cnt)) begin
                                n_finished   = 1'b1;
                                n_res.status = STAT_IGNORED;
                                n_state      = S_DONE;
                            end else begin
                                n_rsat  = (i_in.random_word > RM) ? RM : i_in.random_word;
                                n_dvd   = {1'b0, RM};
                                n_dvs   = DIV_W'(w_rem);
                                n_prem  = '0;
                                n_quo   = '0;
                                n_iter  = '0;
                                n_state = S_DIV1;
                            end
                        end
                        ACT_READ: begin
                            if (10'(i_in.read_index) >= w_cnt) begin
                                n_res.status = STAT_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_RDOUT;
                            end
                        end
                        default: begin
                            n_res.status = STAT_IGNORED;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            // fill entries with 1..count
            S_FILL: begin
                w_we  = 1'b1;
                n_ptr = r_ptr + 10'd1;
                if (11'(r_ptr) + 11'd1 >= 11'(w_cnt)) begin
                    n_state = S_DONE;
                end
            end
            // span = RANDOM_MAX / remaining + 1
            S_DIV1: begin
                n_prem = w_div_prem;
                n_quo  = w_div_quo;
                n_dvd  = w_div_dvd;
                n_iter = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(DIV_ITERS - 1)) begin
                    n_dvs   = w_div_quo + DIV_W'(1);
                    n_dvd   = {1'b0, r_rsat};
                    n_prem  = '0;
                    n_quo   = '0;
                    n_iter  = '0;
                    n_state = S_DIV2;
                end
            end
            // offset = random / span, swap target clamped into the deck
            S_DIV2: begin
                n_prem = w_div_prem;
                n_quo  = w_div_quo;
                n_dvd  = w_div_dvd;
                n_iter = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(DIV_ITERS - 1)) begin
                    if (w_div_quo >= DIV_W'(w_rem)) begin
                        n_j = w_cnt - 10'd1;
                    end else begin
                        n_j = r_step_idx + w_div_quo[9:0];
                    end
                    n_state = S_RD_I;
                end
            end
            S_RD_I: begin
                w_raddr = ADDR_W'(r_step_idx);
                n_state = S_RD_J;
            end
            S_RD_J: begin
                w_raddr = ADDR_W'(r_j);
                n_ti    = r_rd_data;
                n_state = S_SWAP;
            end
            S_SWAP: begin
                w_we    = 1'b1;
                w_waddr = ADDR_W'(r_step_idx);
                w_wdata = r_rd_data;
                n_state = S_WR_J;
            end
            // second write of the swap, then advance the step index
            S_WR_J: begin
                w_we       = 1'b1;
                w_waddr    = ADDR_W'(r_j);
                w_wdata    = r_ti;
                n_step_idx = r_step_idx + 10'd1;
                if (11'(r_step_idx) + 11'd2 >= 11'(w_cnt)) begin
                    n_finished   = 1'b1;
                    n_res.status = STAT_FINISHED;
                end
                n_state = S_DONE;
            end
            // entry read back with its dice faces
            S_RDOUT: begin
                n_res.entry_value = r_rd_data;
                n_res.face_d20    = f_face_d20(r_rd_data);
                n_res.face_d100   = f_face_d100(r_rd_data);
                n_state           = S_DONE;
            end
            // hand the result item to the output register
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_deck_count <= 10'd500;
            r_step_idx   <= '0;
            r_finished   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step_idx   <= n_step_idx;
            r_finished   <= n_finished;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_deck_count <= i_cfg_wr_data;
            end
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_j    <= n_j;
        r_ti   <= n_ti;
        r_rsat <= n_rsat;
        r_dvd  <= n_dvd;
        r_dvs  <= n_dvs;
        r_prem <= n_prem;
        r_quo  <= n_quo;
        r_iter <= n_iter;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // deck table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_deck_table[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_deck_table[w_raddr];
    end

    // a result appears only after the hand-off state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result item raised outside the hand-off state");

    // an accepted item keeps the block busy in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("block free right after taking an item");

    // the shared divider never runs with a zero divisor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1 || r_state == S_DIV2) |-> (r_dvs != '0))
        else $error("divider started with zero divisor");

endmodule

// File: tb/testbench.sv
// self-checking testbench for the fisher-yates shuffle engine
module testbench
    import fys_pkg::*;
();

    localparam int unsigned DEPTH          = 512;
    localparam int unsigned WORD_MAX       = 2147483647;
    localparam logic [1:0]  ACT_UNUSED     = 2'd3;
    localparam logic [30:0] R_MAX          = '1;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          PHASE_ITEMS    = 58;

    // one row of the directed plan: a deck_count write or an item
    typedef struct {
        bit         is_cfg;
        logic [9:0] cfg_value;
        t_in_item   stim;
        bit         typed;
        t_out_item  want;
    } t_plan_row;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_bus;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_bus;
    logic       cfg_en;
    logic [9:0] cfg_data;

    // shadow of the deck and the shuffle position
    logic [9:0]  deck_copy [DEPTH];
    int unsigned step_pos     = 0;
    bit          shuffle_done = 1'b0;
    logic [9:0]  count_reg    = 10'd500;
    int unsigned filled_len   = 0;

    t_out_item   pending_results [$];
    t_plan_row   plan [$];
    int unsigned items_sent  = 0;
    int          errors      = 0;
    int          idle_cycles = 0;
    int          send_idle   = 15;
    int          recv_idle   = 75;

    fisher_yates_shuffle_engine_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in          (in_bus),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out         (out_bus),
        .i_cfg_wr_en   (cfg_en),
        .i_cfg_wr_data (cfg_data)
    );

    // clock, period 4
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // effective count: deck_count held to 1..DEPTH
    function automatic int unsigned deck_size();
        if (count_reg == 10'd0) return 1;
        if (count_reg > DEPTH) return DEPTH;
        return count_reg;
    endfunction

    // an item must never read a deck entry that no init has filled
    function automatic bit safe_to_issue(input t_in_item it);
        int unsigned n;
        n = deck_size();
        if (it.action == ACT_STEP && !shuffle_done && step_pos + 1 < n) return n <= filled_len;
        if (it.action == ACT_READ && it.read_index < n) return it.read_index < filled_len;
        return 1'b1;
    endfunction

    // expected result of one accepted item, updating the shadow deck
    function automatic t_out_item shuffle_predict(input t_in_item it);
        t_out_item   res;
        int unsigned n, i, j, stride, k;
        logic [9:0]  held;
        res = '0;
        n = deck_size();
        case (it.action)
            ACT_INIT: begin
                for (k = 0; k < n; k++) deck_copy[k] = 10'(k + 1);
                step_pos = 0;
                shuffle_done = (n <= 1);
                if (n > filled_len) filled_len = n;
                res.status = STAT_OK;
            end
            ACT_STEP: begin
                i = step_pos;
                if (shuffle_done) begin
                    res.status = STAT_IGNORED;
                end else if (i + 1 >= n) begin
                    // count lowered under a running shuffle
                    shuffle_done = 1'b1;
                    res.status = STAT_IGNORED;
                end else begin
                    stride = WORD_MAX / (n - i) + 1;
                    j = i + it.random_word / stride;
                    if (j >= n) j = n - 1;
                    held = deck_copy[j];
                    deck_copy[j] = deck_copy[i];
                    deck_copy[i] = held;
                    step_pos = i + 1;
                    if (step_pos + 1 >= n) begin
                        shuffle_done = 1'b1;
                        res.status = STAT_FINISHED;
                    end else begin
                        res.status = STAT_OK;
                    end
                end
            end
            ACT_READ: begin
                if (it.read_index >= n) begin
                    res.status = STAT_RANGE;
                end else begin
                    res.entry_value = deck_copy[it.read_index];
                    res.face_d20 = 5'(res.entry_value % 20);
                    res.face_d100 = 7'(res.entry_value % 100);
                    if (res.face_d20 == 5'd0) res.face_d20 = 5'd20;
                    if (res.face_d100 == 7'd0) res.face_d100 = 7'd100;
                    res.status = STAT_OK;
                end
            end
            default: begin
                res.status = STAT_IGNORED;
            end
        endcase
        return res;
    endfunction

    function automatic t_plan_row cfg_row(input logic [9:0] v);
        t_plan_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_value = v;
        return row;
    endfunction

    function automatic t_plan_row item_row(input logic [1:0] act, input logic [30:0] r,
                                           input logic [8:0] idx);
        t_plan_row row;
        row = '{default: '0};
        row.stim.action = act;
        row.stim.random_word = r;
        row.stim.read_index = idx;
        return row;
    endfunction

    function automatic t_plan_row check_row(input logic [1:0] act, input logic [30:0] r,
                                            input logic [8:0] idx, input logic [9:0] v,
                                            input logic [4:0] d20, input logic [6:0] d100,
                                            input t_status st);
        t_plan_row row;
        row = item_row(act, r, idx);
        row.typed = 1'b1;
        row.want.entry_value = v;
        row.want.face_d20 = d20;
        row.want.face_d100 = d100;
        row.want.status = st;
        return row;
    endfunction

    // present one item, hold it until taken, then record its expected result
    task automatic issue_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item predicted;
        if (!safe_to_issue(it)) begin
            it.action = ACT_INIT;
            typed = 1'b0;
        end
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        in_bus <= it;
        do @(posedge clk); while (in_stall);
        predicted = shuffle_predict(it);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // write deck_count once the engine has gone idle
    task automatic load_deck_count(input logic [9:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_en <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_en <= 1'b0;
        count_reg = v;
    endtask

    // mostly whole shuffles with random words and reads, some stray items
    task automatic shuffle_traffic(input int unsigned goal);
        t_in_item    it;
        int unsigned n, k, steps, reads;
        while (items_sent < goal) begin
            n = deck_size();
            it.random_word = 31'($urandom);
            it.read_index = 9'($urandom);
            if ($urandom_range(99) < 80) begin
                it.action = ACT_INIT;
                issue_item(it, 1'b0, '0);
                if ($urandom_range(9) == 0) steps = $urandom_range(n);
                else steps = n - 1 + ($urandom_range(3) == 0);
                for (k = 0; k < steps && items_sent < goal; k++) begin
                    it.action = ACT_STEP;
                    case ($urandom_range(7))
                        0: it.random_word = '0;
                        1: it.random_word = R_MAX;
                        default: it.random_word = 31'($urandom);
                    endcase
                    issue_item(it, 1'b0, '0);
                end
                reads = $urandom_range(1, 5);
                for (k = 0; k < reads && items_sent < goal; k++) begin
                    it.action = ACT_READ;
                    if ($urandom_range(4) == 0) it.read_index = 9'($urandom);
                    else it.read_index = 9'($urandom_range(n - 1));
                    issue_item(it, 1'b0, '0);
                end
            end else begin
                it.action = 2'($urandom);
                issue_item(it, 1'b0, '0);
            end
        end
    endtask

    function automatic void compare_field(input string label, input logic [9:0] want,
                                          input logic [9:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            errors++;
        end
    endfunction

    // result side: check each taken item, stall at random
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, out_bus);
                errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("entry_value", want.entry_value, out_bus.entry_value);
                compare_field("face_d20", want.face_d20, out_bus.face_d20);
                compare_field("face_d100", want.face_d100, out_bus.face_d100);
                compare_field("status", want.status, out_bus.status);
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // stimulus: directed plan, then random phases under three idling mixes
    initial begin
        logic [9:0] deck_plan [12];
        int         p;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_bus <= '0;
        out_stall <= 1'b0;
        cfg_en <= 1'b0;
        cfg_data <= '0;

        // reset state, count 500
        plan.push_back(check_row(ACT_UNUSED, R_MAX, 9'd0, 10'd0, 5'd0, 7'd0, STAT_IGNORED));
        plan.push_back(check_row(ACT_READ, 31'd0, 9'd511, 10'd0, 5'd0, 7'd0, STAT_RANGE));
        plan.push_back(check_row(ACT_INIT, R_MAX, 9'd511, 10'd0, 5'd0, 7'd0, STAT_OK));
        plan.push_back(check_row(ACT_READ, 31'd0, 9'd0, 10'd1, 5'd1, 7'd1, STAT_OK));
        plan.push_back(check_row(ACT_READ, 31'd0, 9'd499, 10'd500, 5'd20, 7'd100, STAT_OK));
        plan.push_back(check_row(ACT_READ, 31'd0, 9'd99, 10'd100, 5'd20, 7'd100, STAT_OK));
        plan.push_back(check_row(ACT_READ, 31'd0, 9'd19, 10'd20, 5'd20, 7'd20, STAT_OK));
        plan.push_back(check_row(ACT_READ, 31'd0, 9'd500, 10'd0, 5'd0, 7'd0, STAT_RANGE));
        // full depth, extreme random words
        plan.push_back(cfg_row(10'd512));
        plan.push_back(check_row(ACT_INIT, 31'd0, 9'd0, 10'd0, 5'd0, 7'd0, STAT_OK));
        plan.push_back(check_row(ACT_READ, 31'd0, 9'd511, 10'd512, 5'd12, 7'd12, STAT_OK));
        plan.push_back(item_row(ACT_STEP, 31'd0, 9'd0));
        plan.push_back(item_row(ACT_STEP, R_MAX, 9'd0));
        plan.push_back(item_row(ACT_READ, 31'd0, 9'd0));
        plan.push_back(item_row(ACT_READ, 31'd0, 9'd1));
        // zero count acts as one: finished right at init
        plan.push_back(cfg_row(10'd0));
        plan.push_back(check_row(ACT_INIT, 31'd0, 9'd0, 10'd0, 5'd0, 7'd0, STAT_OK));
        plan.push_back(check_row(ACT_STEP, R_MAX, 9'd0, 10'd0, 5'd0, 7'd0, STAT_IGNORED));
        plan.push_back(check_row(ACT_READ, 31'd0, 9'd1, 10'd0, 5'd0, 7'd0, STAT_RANGE));
        // two entries: the only swap finishes the shuffle
        plan.push_back(cfg_row(10'd2));
        plan.push_back(check_row(ACT_INIT, 31'd0, 9'd0, 10'd0, 5'd0, 7'd0, STAT_OK));
        plan.push_back(check_row(ACT_STEP, R_MAX, 9'd0, 10'd0, 5'd0, 7'd0, STAT_FINISHED));
        plan.push_back(check_row(ACT_READ, 31'd0, 9'd0, 10'd2, 5'd2, 7'd2, STAT_OK));
        plan.push_back(check_row(ACT_STEP, 31'd0, 9'd0, 10'd0, 5'd0, 7'd0, STAT_IGNORED));
        // count lowered under a running shuffle
        plan.push_back(cfg_row(10'd3));
        plan.push_back(check_row(ACT_INIT, 31'd0, 9'd0, 10'd0, 5'd0, 7'd0, STAT_OK));
        plan.push_back(item_row(ACT_STEP, 31'd0, 9'd0));
        plan.push_back(cfg_row(10'd2));
        plan.push_back(check_row(ACT_STEP, R_MAX, 9'd0, 10'd0, 5'd0, 7'd0, STAT_IGNORED));
        plan.push_back(item_row(ACT_READ, 31'd0, 9'd1));

        deck_plan = '{10'd1023, 10'd9, 10'd0, 10'd40, 10'd2, 10'd512,
                      10'd6, 10'd25, 10'd1, 10'd17, 10'd3, 10'd300};
        deck_plan[7] = 10'($urandom_range(4, 64));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r]) begin
            if (plan[r].is_cfg) load_deck_count(plan[r].cfg_value);
            else issue_item(plan[r].stim, plan[r].typed, plan[r].want);
        end

        for (p = 0; p < 12; p++) begin
            if (p < 4) begin
                send_idle = 15;
                recv_idle = 75;
            end else if (p < 8) begin
                send_idle = 75;
                recv_idle = 15;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            load_deck_count(deck_plan[p]);
            shuffle_traffic(items_sent + PHASE_ITEMS);
        end

        // drain, then allow for stray results
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
